/* design/asc_pkg.sv */
// Shared types, constants and microcode ROM for the Ascon-128 AEAD core.
// No dependencies; used by asc_round and ascon_aead_core_top.
package asc_pkg;

    // Permutation state: five 64-bit lanes x0..x4
    typedef logic [4:0][63:0] state_t;

    // Initialization vector for Ascon-128
    localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;

    // Round numbering follows the 12-round schedule; 6-round runs start at FIRST_P6
    localparam logic [3:0] FIRST_P12 = 4'd0;
    localparam logic [3:0] FIRST_P6  = 4'd6;
    localparam logic [3:0] LAST_RND  = 4'd11;

    // Input item kinds (tuser)
    typedef enum logic [1:0] {
        FN_START  = 2'd0,
        FN_AD     = 2'd1,
        FN_DATA   = 2'd2,
        FN_FINISH = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_DECRYPT  = 2'd2
    } cfg_idx_t;

    // Microcode operations
    typedef enum logic [3:0] {
        OP_IDLE,    // wait for an input transfer, dispatch on its kind
        OP_LOAD,    // load IV, key, nonce
        OP_ROUND,   // one permutation round; repeat until the last round
        OP_KEY,     // x3,x4 ^= key after initialization
        OP_ADX,     // absorb associated data unless already separated
        OP_DCHK,    // run owed rounds before a data block if any
        OP_DATA,    // absorb/squeeze one data block, emit result
        OP_FIN,     // separation, key into x1,x2 before final rounds
        OP_TAG      // emit tag and match flag
    } op_t;

    typedef logic [3:0] upc_t;

    // Control word: operation, next step, alternate step on condition
    typedef struct packed {
        op_t  op;
        upc_t nxt;
        upc_t alt;
    } uword_t;

    // Program addresses
    localparam upc_t A_IDLE  = 4'd0;
    localparam upc_t A_LOAD  = 4'd1;
    localparam upc_t A_RND_I = 4'd2;
    localparam upc_t A_KEY   = 4'd3;
    localparam upc_t A_ADX   = 4'd4;
    localparam upc_t A_RND_A = 4'd5;
    localparam upc_t A_DCHK  = 4'd6;
    localparam upc_t A_RND_D = 4'd7;
    localparam upc_t A_DATA  = 4'd8;
    localparam upc_t A_FIN   = 4'd9;
    localparam upc_t A_RND_F = 4'd10;
    localparam upc_t A_TAG   = 4'd11;

    // Microcode ROM
    function automatic uword_t ucode(input upc_t addr);
        uword_t w;
        unique case (addr)
            A_IDLE:  w = '{op: OP_IDLE,  nxt: A_IDLE,  alt: A_IDLE};
            A_LOAD:  w = '{op: OP_LOAD,  nxt: A_RND_I, alt: A_IDLE};
            A_RND_I: w = '{op: OP_ROUND, nxt: A_KEY,   alt: A_IDLE};
            A_KEY:   w = '{op: OP_KEY,   nxt: A_IDLE,  alt: A_IDLE};
            A_ADX:   w = '{op: OP_ADX,   nxt: A_RND_A, alt: A_IDLE};
            A_RND_A: w = '{op: OP_ROUND, nxt: A_IDLE,  alt: A_IDLE};
            A_DCHK:  w = '{op: OP_DCHK,  nxt: A_RND_D, alt: A_DATA};
            A_RND_D: w = '{op: OP_ROUND, nxt: A_DATA,  alt: A_IDLE};
            A_DATA:  w = '{op: OP_DATA,  nxt: A_IDLE,  alt: A_IDLE};
            A_FIN:   w = '{op: OP_FIN,   nxt: A_RND_F, alt: A_IDLE};
            A_RND_F: w = '{op: OP_ROUND, nxt: A_TAG,   alt: A_IDLE};
            A_TAG:   w = '{op: OP_TAG,   nxt: A_IDLE,  alt: A_IDLE};
            default: w = '{op: OP_IDLE,  nxt: A_IDLE,  alt: A_IDLE};
        endcase
        return w;
    endfunction

    // Entry point of each item's program
    function automatic upc_t entry(input func_t fn);
        upc_t a;
        unique case (fn)
            FN_START:  a = A_LOAD;
            FN_AD:     a = A_ADX;
            FN_DATA:   a = A_DCHK;
            FN_FINISH: a = A_FIN;
            default:   a = A_IDLE;
        endcase
        return a;
    endfunction

endpackage

/* design/asc_round.sv */
// One Ascon permutation round: constant addition, S-box layer, linear layer.
// Depends on asc_pkg (state_t).
module asc_round (
    input  asc_pkg::state_t x_in,
    input  logic [7:0]      rc,
    output asc_pkg::state_t x_out
);
    import asc_pkg::*;

    state_t p;
    state_t q;
    state_t r;

    // Constant addition and S-box input mixing
    assign p[0] = x_in[0] ^ x_in[4];
    assign p[1] = x_in[1];
    assign p[2] = x_in[2] ^ {56'd0, rc} ^ x_in[1];
    assign p[3] = x_in[3];
    assign p[4] = x_in[4] ^ x_in[3];

    // Chi-like nonlinear step
    assign q[0] = p[0] ^ (~p[1] & p[2]);
    assign q[1] = p[1] ^ (~p[2] & p[3]);
    assign q[2] = p[2] ^ (~p[3] & p[4]);
    assign q[3] = p[3] ^ (~p[4] & p[0]);
    assign q[4] = p[4] ^ (~p[0] & p[1]);

    // S-box output mixing
    assign r[0] = q[0] ^ q[4];
    assign r[1] = q[1] ^ q[0];
    assign r[2] = ~q[2];
    assign r[3] = q[3] ^ q[2];
    assign r[4] = q[4];

    // Linear diffusion, rotate right
    assign x_out[0] = r[0] ^ {r[0][18:0], r[0][63:19]} ^ {r[0][27:0], r[0][63:28]};
    assign x_out[1] = r[1] ^ {r[1][60:0], r[1][63:61]} ^ {r[1][38:0], r[1][63:39]};
    assign x_out[2] = r[2] ^ {r[2][0],    r[2][63:1]}  ^ {r[2][5:0],  r[2][63:6]};
    assign x_out[3] = r[3] ^ {r[3][9:0],  r[3][63:10]} ^ {r[3][16:0], r[3][63:17]};
    assign x_out[4] = r[4] ^ {r[4][6:0],  r[4][63:7]}  ^ {r[4][40:0], r[4][63:41]};

endmodule

/* design/ascon_aead_core_top.sv */
// Ascon-128 AEAD core, top level: microcode sequencer, state and output register.
// Depends on asc_pkg and asc_round.
//
// Usage:
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the key
//   halves and the decrypt flag; write it only while the core is idle.
//   Input stream s_axis_*: tuser selects start, associated data, data or finish;
//   tdata carries the words. An input transfer is taken only when the sequencer
//   sits at its idle step; the item then runs its microprogram, one step a cycle
//   except while an emit step waits for the output register. Associated data is
//   ignored after separation; a later data block first runs the owed rounds.
//   Rounds run on the single round unit, one permutation round per cycle.
//   Output stream m_axis_*: one result per data or finish item, held in an output
//   register. The sequencer keeps working while a result waits and stalls only at
//   its next emit step if the receiver has not taken the previous result.
//   Reset clears the permutation state, phase flags, key and mode to zero and
//   leaves the output channel empty.
module ascon_aead_core_top (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // word_a [63:0], word_b [127:64]
    input  logic [1:0]   s_axis_tuser,   // func [1:0]
    // output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata,   // data_word [63:0], tag_high [127:64],
                                         // tag_low [191:128], tag_match [192], zero
    output logic [0:0]   m_axis_tuser    // is_tag [0]
);
    import asc_pkg::*;

    // Control state
    upc_t        upc_reg, upc_next;
    logic [3:0]  rnd_reg, rnd_next;
    logic        sep_reg, sep_next;
    logic        pend_reg, pend_next;
    state_t      x_reg, x_next;
    logic [63:0] kh_reg, kh_next;
    logic [63:0] kl_reg, kl_next;
    logic        dec_reg, dec_next;
    logic        ov_reg, ov_next;

    // Payload registers
    logic [63:0] wa_reg, wb_reg;
    logic        o_tag_reg, o_tag_next;
    logic [63:0] o_data_reg, o_data_next;
    logic [63:0] o_th_reg, o_th_next;
    logic [63:0] o_tl_reg, o_tl_next;
    logic        o_match_reg, o_match_next;

    uword_t      uw;
    state_t      x_rnd;
    logic [7:0]  rc;
    logic        in_xfer;
    logic        out_free;
    logic        emit;
    logic [63:0] res;
    logic [63:0] th;
    logic [63:0] tl;

    assign uw            = ucode(upc_reg);
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (uw.op == OP_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ov_reg || m_axis_tready;
    assign emit          = out_free && (uw.op == OP_DATA || uw.op == OP_TAG);

    // Round constant for the current round index
    assign rc = {4'hF - rnd_reg, rnd_reg};

    asc_round u_round (
        .x_in  (x_reg),
        .rc    (rc),
        .x_out (x_rnd)
    );

    // Data block and tag values
    assign res = x_reg[0] ^ wa_reg;
    assign th  = x_reg[3] ^ kh_reg;
    assign tl  = x_reg[4] ^ kl_reg;

    // Sequencer and datapath next state
    always_comb
    begin
        upc_next     = upc_reg;
        rnd_next     = rnd_reg;
        sep_next     = sep_reg;
        pend_next    = pend_reg;
        x_next       = x_reg;
        kh_next      = kh_reg;
        kl_next      = kl_reg;
        dec_next     = dec_reg;
        ov_next      = ov_reg && !m_axis_tready;
        o_tag_next   = o_tag_reg;
        o_data_next  = o_data_reg;
        o_th_next    = o_th_reg;
        o_tl_next    = o_tl_reg;
        o_match_next = o_match_reg;

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KEY_HIGH: kh_next  = cfg_data;
                CFG_KEY_LOW:  kl_next  = cfg_data;
                CFG_DECRYPT:  dec_next = cfg_data[0];
                default:      ;
            endcase
        end

        unique case (uw.op)
            OP_IDLE:
            begin
                if (in_xfer)
                    upc_next = entry(func_t'(s_axis_tuser));
            end
            OP_LOAD:
            begin
                x_next[0] = ASCON_IV;
                x_next[1] = kh_reg;
                x_next[2] = kl_reg;
                x_next[3] = wa_reg;
                x_next[4] = wb_reg;
                rnd_next  = FIRST_P12;
                upc_next  = uw.nxt;
            end
            OP_ROUND:
            begin
                x_next = x_rnd;
                if (rnd_reg == LAST_RND)
                    upc_next = uw.nxt;
                else
                    rnd_next = rnd_reg + 4'd1;
            end
            OP_KEY:
            begin
                x_next[3] = x_reg[3] ^ kh_reg;
                x_next[4] = x_reg[4] ^ kl_reg;
                sep_next  = 1'b0;
                pend_next = 1'b0;
                upc_next  = uw.nxt;
            end
            OP_ADX:
            begin
                if (sep_reg)
                    upc_next = uw.alt;
                else
                begin
                    x_next[0] = x_reg[0] ^ wa_reg;
                    rnd_next  = FIRST_P6;
                    upc_next  = uw.nxt;
                end
            end
            OP_DCHK:
            begin
                if (pend_reg)
                begin
                    rnd_next = FIRST_P6;
                    upc_next = uw.nxt;
                end
                else
                    upc_next = uw.alt;
            end
            OP_DATA:
            begin
                if (out_free)
                begin
                    // separation is due once, before the first data block
                    if (!sep_reg)
                        x_next[4] = x_reg[4] ^ 64'd1;
                    sep_next     = 1'b1;
                    x_next[0]    = dec_reg ? wa_reg : res;
                    pend_next    = 1'b1;
                    ov_next      = 1'b1;
                    o_tag_next   = 1'b0;
                    o_data_next  = res;
                    o_th_next    = '0;
                    o_tl_next    = '0;
                    o_match_next = 1'b0;
                    upc_next     = uw.nxt;
                end
            end
            OP_FIN:
            begin
                x_next[1] = x_reg[1] ^ kh_reg;
                x_next[2] = x_reg[2] ^ kl_reg;
                x_next[4] = sep_reg ? x_reg[4] : (x_reg[4] ^ 64'd1);
                sep_next  = 1'b1;
                pend_next = 1'b0;
                rnd_next  = FIRST_P12;
                upc_next  = uw.nxt;
            end
            OP_TAG:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_tag_next   = 1'b1;
                    o_data_next  = '0;
                    o_th_next    = th;
                    o_tl_next    = tl;
                    o_match_next = dec_reg && th == wa_reg && tl == wb_reg;
                    upc_next     = uw.nxt;
                end
            end
            default: upc_next = A_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= A_IDLE;
            rnd_reg  <= FIRST_P12;
            sep_reg  <= 1'b0;
            pend_reg <= 1'b0;
            x_reg    <= '0;
            kh_reg   <= '0;
            kl_reg   <= '0;
            dec_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            rnd_reg  <= rnd_next;
            sep_reg  <= sep_next;
            pend_reg <= pend_next;
            x_reg    <= x_next;
            kh_reg   <= kh_next;
            kl_reg   <= kl_next;
            dec_reg  <= dec_next;
            ov_reg   <= ov_next;
        end
    end

    // Input words and output payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            wa_reg <= s_axis_tdata[63:0];
            wb_reg <= s_axis_tdata[127:64];
        end
        o_tag_reg   <= o_tag_next;
        o_data_reg  <= o_data_next;
        o_th_reg    <= o_th_next;
        o_tl_reg    <= o_tl_next;
        o_match_reg <= o_match_next;
    end

    assign m_axis_tvalid   = ov_reg;
    assign m_axis_tuser[0] = o_tag_reg;
    assign m_axis_tdata    = {7'd0, o_match_reg, o_tl_reg, o_th_reg, o_data_reg};

    // Round index never runs past the last round
    a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg <= LAST_RND)
        else $error("round index out of range");

    // An accepted item always leaves the idle step
    a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> upc_reg != A_IDLE)
        else $error("accepted item not dispatched");

    // After the tag is emitted no data rounds are owed and separation is done
    a_tag_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == OP_TAG && emit) |=> (!pend_reg && sep_reg && m_axis_tvalid))
        else $error("phase flags wrong after tag");

    // Initialization leaves the separation and pending flags clear
    a_init_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == OP_KEY) |=> (!sep_reg && !pend_reg))
        else $error("phase flags wrong after initialization");

    // Data emit comes after any owed rounds; afterwards rounds are owed, separation done, no tag
    a_data_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == OP_DATA && emit) |=> (pend_reg && sep_reg && !m_axis_tuser[0]))
        else $error("data emit flags wrong");

endmodule

/* tb/sv/tb_ascon_aead_core_top.sv */
// Self-checking testbench for the Ascon-128 AEAD core (ascon_aead_core_top).
// Depends on asc_pkg for item kinds, register indexes, state type and the IV.
// A scoreboard class tracks the cipher state and checks every result transfer.
module tb_ascon_aead_core_top;
    timeunit 1ns;
    timeprecision 1ps;

    import asc_pkg::*;

    localparam int ITEM_TARGET = 900;
    localparam int HOLD_AT     = 300;   // input count at which the long output stall starts
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 24;    // covers the longest item without a result, a start
    // slowest handshake gap: a start item, sender gap, output stall and the long hold
    localparam int STALL_LIMIT = 3000;

    // One result transfer, unpacked
    typedef struct packed {
        logic        is_tag;
        logic [63:0] data_word;
        logic [63:0] tag_high;
        logic [63:0] tag_low;
        logic        tag_match;
    } result_t;

    // Cipher state as the core keeps it
    typedef struct packed {
        state_t x;
        logic   separated;
        logic   data_pending;
    } core_ctx_t;

    // Tracks the core's state and configuration; holds results still owed
    class aead_scoreboard;
        core_ctx_t   ctx;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic        decrypting;
        result_t     owed_results[$];
        int          fails;

        function new();
            ctx          = '0;
            key_hi       = '0;
            key_lo       = '0;
            decrypting   = 1'b0;
            fails        = 0;
        endfunction

        function void report(string msg);
            $display("%0t ns: %s", $realtime, msg);
            fails++;
        endfunction

        function void load_register(cfg_idx_t idx, logic [63:0] val);
            case (idx)
                CFG_KEY_HIGH: key_hi = val;
                CFG_KEY_LOW:  key_lo = val;
                CFG_DECRYPT:  decrypting = val[0];
                default: ;
            endcase
        endfunction

        function logic [63:0] rotr(logic [63:0] v, int n);
            return (v >> n) | (v << (64 - n));
        endfunction

        // Last `count` rounds of the 12-round schedule
        function state_t permute(state_t s, int count);
            logic [63:0] t0, t1, t2, t3, t4;
            for (int i = 12 - count; i < 12; i++)
            begin
                s[2] ^= 64'((15 - i) * 16 + i);
                s[0] ^= s[4]; s[4] ^= s[3]; s[2] ^= s[1];
                t0 = ~s[0] & s[1]; t1 = ~s[1] & s[2]; t2 = ~s[2] & s[3];
                t3 = ~s[3] & s[4]; t4 = ~s[4] & s[0];
                s[0] ^= t1; s[1] ^= t2; s[2] ^= t3; s[3] ^= t4; s[4] ^= t0;
                s[1] ^= s[0]; s[0] ^= s[4]; s[3] ^= s[2]; s[2] = ~s[2];
                s[0] ^= rotr(s[0], 19) ^ rotr(s[0], 28);
                s[1] ^= rotr(s[1], 61) ^ rotr(s[1], 39);
                s[2] ^= rotr(s[2], 1) ^ rotr(s[2], 6);
                s[3] ^= rotr(s[3], 10) ^ rotr(s[3], 17);
                s[4] ^= rotr(s[4], 7) ^ rotr(s[4], 41);
            end
            return s;
        endfunction

        // Domain separation, applied once per message
        function void separate(ref core_ctx_t c);
            if (!c.separated)
            begin
                c.x[4] ^= 64'd1;
                c.separated = 1'b1;
            end
        endfunction

        // Advances a state by one item; returns 1 when the item gives a result
        function bit advance_core(ref core_ctx_t c, input func_t f,
                                  input logic [63:0] a, input logic [63:0] b,
                                  output result_t r);
            r = '0;
            case (f)
                FN_START:
                begin
                    c.x[0] = ASCON_IV;
                    c.x[1] = key_hi;
                    c.x[2] = key_lo;
                    c.x[3] = a;
                    c.x[4] = b;
                    c.x = permute(c.x, 12);
                    c.x[3] ^= key_hi;
                    c.x[4] ^= key_lo;
                    c.separated = 1'b0;
                    c.data_pending = 1'b0;
                    return 1'b0;
                end
                FN_AD:
                begin
                    // ignored once separation has happened
                    if (!c.separated)
                    begin
                        c.x[0] ^= a;
                        c.x = permute(c.x, 6);
                    end
                    return 1'b0;
                end
                FN_DATA:
                begin
                    // rounds owed by the previous block run now
                    if (c.data_pending)
                        c.x = permute(c.x, 6);
                    separate(c);
                    r.data_word = c.x[0] ^ a;
                    c.x[0] = decrypting ? a : r.data_word;
                    c.data_pending = 1'b1;
                    return 1'b1;
                end
                default:
                begin
                    separate(c);
                    c.data_pending = 1'b0;
                    c.x[1] ^= key_hi;
                    c.x[2] ^= key_lo;
                    c.x = permute(c.x, 12);
                    r.is_tag = 1'b1;
                    r.tag_high = c.x[3] ^ key_hi;
                    r.tag_low = c.x[4] ^ key_lo;
                    r.tag_match = decrypting && r.tag_high == a && r.tag_low == b;
                    return 1'b1;
                end
            endcase
        endfunction

        function void note_input(func_t f, logic [63:0] a, logic [63:0] b);
            result_t r;
            if (advance_core(ctx, f, a, b, r))
                owed_results.push_back(r);
        endfunction

        // Tag a finish would give from the current state, {high, low}
        function logic [127:0] peek_tag();
            core_ctx_t c;
            result_t   r;
            c = ctx;
            void'(advance_core(c, FN_FINISH, '0, '0, r));
            return {r.tag_high, r.tag_low};
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (owed_results.size() == 0)
            begin
                report($sformatf("result transfer with none owed: %h", got));
                return;
            end
            want = owed_results.pop_front();
            if (got.is_tag !== want.is_tag)
                report($sformatf("is_tag got %b want %b", got.is_tag, want.is_tag));
            if (got.data_word !== want.data_word)
                report($sformatf("data_word got %h want %h", got.data_word, want.data_word));
            if (got.tag_high !== want.tag_high)
                report($sformatf("tag_high got %h want %h", got.tag_high, want.tag_high));
            if (got.tag_low !== want.tag_low)
                report($sformatf("tag_low got %h want %h", got.tag_low, want.tag_low));
            if (got.tag_match !== want.tag_match)
                report($sformatf("tag_match got %b want %b", got.tag_match, want.tag_match));
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // word_a [63:0], word_b [127:64]
    logic [1:0]   s_axis_tuser;   // func [1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;   // data_word, tag_high, tag_low, tag_match
    logic [0:0]   m_axis_tuser;   // is_tag [0]

    aead_scoreboard sb;
    int items_sent;
    int burst_left;

    ascon_aead_core_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock and known input levels from time zero
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_KEY_HIGH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FN_START;
        m_axis_tready = 1'b0;
        items_sent    = 0;
        burst_left    = 0;
        sb            = new();
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] rand_key();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Input transfer; the sender works in bursts with random gaps, sometimes none, between them
    task automatic send_item(func_t f, logic [63:0] a, logic [63:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= f;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(f, a, b);
        items_sent++;
    endtask

    // Finish item; the expected tag is right, one bit off, or random
    task automatic send_finish();
        logic [127:0] tag;
        tag = sb.peek_tag();
        case ($urandom_range(0, 3))
            2:       tag ^= 128'd1 << $urandom_range(0, 127);
            3:       tag = {rand_word(), rand_word()};
            default: ;
        endcase
        send_item(FN_FINISH, tag[127:64], tag[63:0]);
    endtask

    // Drain: all results in, then let a result-free item finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register writes selected by mask, back to back
    task automatic write_config(logic [2:0] mask, logic [63:0] kh, logic [63:0] kl,
                                logic dec);
        cfg_idx_t    idx;
        logic [63:0] val;
        for (int i = 0; i < 3; i++)
        begin
            if (mask[i])
            begin
                idx = cfg_idx_t'(i);
                case (idx)
                    CFG_KEY_HIGH: val = kh;
                    CFG_KEY_LOW:  val = kl;
                    default:      val = {63'd0, dec};
                endcase
                cfg_valid <= 1'b1;
                cfg_index <= idx;
                cfg_data  <= val;
                do @(posedge clk); while (!cfg_ready);
                sb.load_register(idx, val);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Receiver: ready pattern of its own plus one long hold-off
    initial
    begin
        result_t got;
        int      mode;
        int      mode_left;
        int      hold_left;
        bit      held;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.is_tag    = m_axis_tuser[0];
                got.data_word = m_axis_tdata[63:0];
                got.tag_high  = m_axis_tdata[127:64];
                got.tag_low   = m_axis_tdata[191:128];
                got.tag_match = m_axis_tdata[192];
                sb.check_result(got);
            end
            if (!held && items_sent >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        bit           first;
        int           n_ad;
        int           n_data;
        logic [127:0] tag;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // items before any start, zero key, encrypt
        send_item(FN_AD, rand_word(), rand_word());
        send_item(FN_DATA, '0, '0);
        send_item(FN_FINISH, '1, '1);
        // data after finish, then associated data after separation
        send_item(FN_DATA, '1, '0);
        send_item(FN_AD, '1, '1);
        settle();

        // all-ones key, encrypt: full message, then finish with no data
        write_config(3'b111, '1, '1, 1'b0);
        send_item(FN_START, '0, '0);
        send_item(FN_AD, '1, '0);
        send_item(FN_AD, '0, '1);
        send_item(FN_DATA, '1, '1);
        send_item(FN_DATA, '0, '1);
        send_item(FN_AD, rand_word(), rand_word());
        send_finish();
        send_item(FN_START, '1, '1);
        send_finish();
        settle();

        // random key, decrypt with matching and wrong tags
        write_config(3'b111, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        send_item(FN_START, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(FN_AD, {$urandom, $urandom}, '0);
        send_item(FN_DATA, {$urandom, $urandom}, '0);
        send_item(FN_DATA, '1, '0);
        tag = sb.peek_tag();
        send_item(FN_FINISH, tag[127:64], tag[63:0]);
        send_item(FN_START, {$urandom, $urandom}, {$urandom, $urandom});
        send_item(FN_DATA, {$urandom, $urandom}, '1);
        tag = sb.peek_tag();
        send_item(FN_FINISH, ~tag[127:64], tag[63:0]);
        send_item(FN_START, rand_word(), rand_word());
        tag = sb.peek_tag();
        send_item(FN_FINISH, tag[127:64], tag[63:0]);

        // random phases, each after writes to a random subset of the registers
        first = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            write_config(first ? 3'b111 : 3'($urandom_range(0, 7)),
                         rand_key(), rand_key(), 1'($urandom_range(0, 1)));
            first = 1'b0;
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 6) != 0)
                begin
                    // well-formed message with random content
                    n_ad   = $urandom_range(0, 3);
                    n_data = $urandom_range(0, 5);
                    send_item(FN_START, rand_word(), rand_word());
                    repeat (n_ad) send_item(FN_AD, rand_word(), rand_word());
                    repeat (n_data) send_item(FN_DATA, rand_word(), rand_word());
                    if ($urandom_range(0, 7) == 0)
                        send_item(FN_AD, rand_word(), rand_word());
                    send_finish();
                end
                else
                begin
                    // noise: any kind in any order
                    repeat ($urandom_range(1, 6))
                        send_item(func_t'($urandom_range(0, 3)), rand_word(), rand_word());
                end
            end
        end

        settle();
        if (sb.fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
